// ===== src/sfa_pkg.sv =====
// Shared types and constants of the sprite frame animation sequencer.
// No dependencies; imported by sfa_serdiv and the top level.
package sfa_pkg;

	// Width of the iteration count handed to the serial divider.
	localparam int DIV_CNT_W = 6;

	// Width of the atlas source coordinates.
	localparam int POS_W = 23;

	// Control from the sequencer to the serial divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] bits;
	} div_ctl_t;

endpackage

// ===== src/sfa_serdiv.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Depends on sfa_pkg (div_ctl_t, DIV_CNT_W).
module sfa_serdiv
	import sfa_pkg::*;
#(
	parameter int NW = 22,
	parameter int DW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_ctl_t      ctl,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NW-1:0]        qd_q;
	logic [DW-1:0]        r_q;
	logic [DW-1:0]        d_q;
	logic [DW:0]          rs;
	logic [DW:0]          diff;
	logic                 ge;

	// Bring down the next dividend bit and try the subtraction.
	assign rs   = {r_q, qd_q[NW-1]};
	assign ge   = rs >= {1'b0, d_q};
	assign diff = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= ctl.bits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			qd_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (cnt_q != '0) begin
			qd_q <= {qd_q[NW-2:0], ge};
			r_q  <= ge ? diff[DW-1:0] : rs[DW-1:0];
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = qd_q;
	assign remainder = r_q;

endmodule

// ===== src/sprite_frame_animation_sequencer.sv =====
// Sprite frame animation sequencer: frame timing, loop/hold and atlas position.
// Depends on sfa_pkg and sfa_serdiv (shared bit-serial divider).
//
//  channel  | signals                                      | direction
//  ---------+----------------------------------------------+----------
//  request  | in_valid, in_ready, req_type, tick_time      | in
//  result   | out_valid, out_ready, frame_changed,         | out
//           | frame_index, is_playing, is_finished,        |
//           | source_x, source_y                           |
//  config   | psel, penable, pwrite, paddr, pwdata,        | in/out
//           | prdata, pready                               |
//
// One request at a time. A restart, or a tick that does not step, runs the atlas
// division and then the multiply; a tick that steps first divides the elapsed time
// by the frame period, and a looping animation that wraps adds a division by the
// frame total. The dividend width is NW = max(TIME_WIDTH+1, INDEX_WIDTH) + 1. The
// shared divider retires one quotient bit per cycle, and the shift-add multiplier
// takes one multiplier bit per cycle.
// Reset (arst_n low) restores the register defaults and the restart state.
// A result that is not taken holds in the output register; the next request is
// accepted meanwhile and its result waits until the register is free.
module sprite_frame_animation_sequencer
	import sfa_pkg::*;
#(
	parameter int TIME_WIDTH  = 20,
	parameter int INDEX_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   req_type,
	input  logic [TIME_WIDTH-1:0]  tick_time,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   frame_changed,
	output logic [INDEX_WIDTH-1:0] frame_index,
	output logic                   is_playing,
	output logic                   is_finished,
	output logic [POS_W-1:0]       source_x,
	output logic [POS_W-1:0]       source_y,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// Elapsed time needs one bit above a tick.
	localparam int EW  = TIME_WIDTH + 1;
	// Dividend width: current frame plus a whole step count, with a carry.
	localparam int NW  = ((EW > INDEX_WIDTH) ? EW : INDEX_WIDTH) + 1;
	// Divisor width: frame period, frame total or atlas columns.
	localparam int DW  = (TIME_WIDTH > INDEX_WIDTH) ? TIME_WIDTH : INDEX_WIDTH;
	// Multiplier length: row index or column index (columns < 256).
	localparam int MW  = (INDEX_WIDTH > 8) ? INDEX_WIDTH : 8;
	localparam int MCW = $clog2(MW + 1);

	// Register map, byte address = 4 * index.
	localparam logic [2:0] REG_FRAME_PERIOD  = 3'd0;
	localparam logic [2:0] REG_FRAME_TOTAL   = 3'd1;
	localparam logic [2:0] REG_LOOP_ENABLE   = 3'd2;
	localparam logic [2:0] REG_ATLAS_COLUMNS = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X      = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd5;
	localparam logic [2:0] REG_CELL_WIDTH    = 3'd6;
	localparam logic [2:0] REG_CELL_HEIGHT   = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVT,
		ST_CHK,
		ST_DIVW,
		ST_ATLAS,
		ST_DIVA,
		ST_MUL,
		ST_FIN
	} state_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [TIME_WIDTH-1:0]  frame_period_q;
	logic [INDEX_WIDTH-1:0] frame_total_q;
	logic                   loop_enable_q;
	logic [7:0]             atlas_columns_q;
	logic [15:0]            origin_x_q;
	logic [15:0]            origin_y_q;
	logic [11:0]            cell_width_q;
	logic [11:0]            cell_height_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q  <= '0;
			frame_total_q   <= '0;
			loop_enable_q   <= 1'b0;
			atlas_columns_q <= 8'd1;
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			cell_width_q    <= '0;
			cell_height_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_FRAME_PERIOD:  frame_period_q  <= pwdata[TIME_WIDTH-1:0];
				REG_FRAME_TOTAL:   frame_total_q   <= pwdata[INDEX_WIDTH-1:0];
				REG_LOOP_ENABLE:   loop_enable_q   <= pwdata[0];
				REG_ATLAS_COLUMNS: atlas_columns_q <= pwdata[7:0];
				REG_ORIGIN_X:      origin_x_q      <= pwdata[15:0];
				REG_ORIGIN_Y:      origin_y_q      <= pwdata[15:0];
				REG_CELL_WIDTH:    cell_width_q    <= pwdata[11:0];
				REG_CELL_HEIGHT:   cell_height_q   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_FRAME_PERIOD:  prdata = 32'(frame_period_q);
			REG_FRAME_TOTAL:   prdata = 32'(frame_total_q);
			REG_LOOP_ENABLE:   prdata = 32'(loop_enable_q);
			REG_ATLAS_COLUMNS: prdata = 32'(atlas_columns_q);
			REG_ORIGIN_X:      prdata = 32'(origin_x_q);
			REG_ORIGIN_Y:      prdata = 32'(origin_y_q);
			REG_CELL_WIDTH:    prdata = 32'(cell_width_q);
			REG_CELL_HEIGHT:   prdata = 32'(cell_height_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Shared serial divider: whole periods, loop wrap, atlas row/column
	// ---------------------------------------------------------------
	div_ctl_t      div_ctl_q;
	logic [NW-1:0] div_dvd_q;
	logic [DW-1:0] div_dvs_q;
	logic          div_busy;
	logic [NW-1:0] div_quo;
	logic [DW-1:0] div_rem;
	logic          div_done;

	sfa_serdiv #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl_q),
		.dividend  (div_dvd_q),
		.divisor   (div_dvs_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// The start pulse is registered with the state move, before the divider shows busy; wait past it.
	assign div_done = !div_busy && !div_ctl_q.start;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	state_t                 state_q;
	logic [EW-1:0]          elapsed_q;
	logic [INDEX_WIDTH-1:0] frame_q;
	logic                   playing_q;
	logic                   finished_q;
	logic                   chg_q;
	logic [NW-1:0]          next_q;

	// shift-add multiplier
	logic [MCW-1:0]         mul_cnt_q;
	logic [MW-1:0]          mx_q;
	logic [MW-1:0]          my_q;
	logic [POS_W-1:0]       wsh_q;
	logic [POS_W-1:0]       hsh_q;
	logic [POS_W-1:0]       sx_q;
	logic [POS_W-1:0]       sy_q;

	// output register
	logic                   out_valid_q;
	logic                   o_chg_q;
	logic [INDEX_WIDTH-1:0] o_frame_q;
	logic                   o_playing_q;
	logic                   o_finished_q;
	logic [POS_W-1:0]       o_sx_q;
	logic [POS_W-1:0]       o_sy_q;

	logic [EW-1:0]          e_sum;
	logic                   e_short;
	logic                   next_lt;
	logic [7:0]             cols_eff;
	logic                   out_free;

	assign e_sum    = elapsed_q + EW'(tick_time);
	assign e_short  = e_sum < EW'(frame_period_q);
	assign next_lt  = next_q < NW'(frame_total_q);
	assign cols_eff = (atlas_columns_q == 8'd0) ? 8'd1 : atlas_columns_q;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			frame_q      <= '0;
			playing_q    <= 1'b1;
			finished_q   <= 1'b0;
			chg_q        <= 1'b0;
			next_q       <= '0;
			div_ctl_q    <= '0;
			div_dvd_q    <= '0;
			div_dvs_q    <= '0;
			mul_cnt_q    <= '0;
			mx_q         <= '0;
			my_q         <= '0;
			wsh_q        <= '0;
			hsh_q        <= '0;
			sx_q         <= '0;
			sy_q         <= '0;
			out_valid_q  <= 1'b0;
			o_chg_q      <= 1'b0;
			o_frame_q    <= '0;
			o_playing_q  <= 1'b0;
			o_finished_q <= 1'b0;
			o_sx_q       <= '0;
			o_sy_q       <= '0;
		end else begin
			// load a finished result when the register is free, drop it once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// start is a single-cycle pulse, raised only where a division begins
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						chg_q <= 1'b0;
						if (req_type) begin
							// restart
							frame_q         <= '0;
							elapsed_q       <= '0;
							playing_q       <= 1'b1;
							finished_q      <= 1'b0;
							div_ctl_q.start <= 1'b0;
							state_q         <= ST_ATLAS;
						end else if (!playing_q || frame_total_q == '0 ||
							frame_period_q == '0) begin
							div_ctl_q.start <= 1'b0;
							state_q         <= ST_ATLAS;
						end else if (e_short) begin
							elapsed_q       <= e_sum;
							div_ctl_q.start <= 1'b0;
							state_q         <= ST_ATLAS;
						end else begin
							// whole periods: e_sum / frame_period
							div_ctl_q.start <= 1'b1;
							div_ctl_q.bits  <= DIV_CNT_W'(EW);
							div_dvd_q       <= NW'(e_sum) << (NW - EW);
							div_dvs_q       <= DW'(frame_period_q);
							state_q         <= ST_DIVT;
						end
					end else begin
						div_ctl_q.start <= 1'b0;
					end
				end

				ST_DIVT: begin
					div_ctl_q.start <= 1'b0;
					if (div_done) begin
						elapsed_q <= EW'(div_rem);
						next_q    <= NW'(frame_q) + NW'(div_quo[EW-1:0]);
						chg_q     <= 1'b1;
						state_q   <= ST_CHK;
					end
				end

				ST_CHK: begin
					if (next_lt) begin
						frame_q         <= next_q[INDEX_WIDTH-1:0];
						div_ctl_q.start <= 1'b0;
						state_q         <= ST_ATLAS;
					end else if (loop_enable_q) begin
						// wrap: next % frame_total
						div_ctl_q.start <= 1'b1;
						div_ctl_q.bits  <= DIV_CNT_W'(NW);
						div_dvd_q       <= next_q;
						div_dvs_q       <= DW'(frame_total_q);
						state_q         <= ST_DIVW;
					end else begin
						// hold the last frame and stop
						frame_q         <= frame_total_q - 1'b1;
						playing_q       <= 1'b0;
						finished_q      <= 1'b1;
						div_ctl_q.start <= 1'b0;
						state_q         <= ST_ATLAS;
					end
				end

				ST_DIVW: begin
					div_ctl_q.start <= 1'b0;
					if (div_done) begin
						frame_q <= div_rem[INDEX_WIDTH-1:0];
						state_q <= ST_ATLAS;
					end
				end

				ST_ATLAS: begin
					// row and column: frame / columns
					div_ctl_q.start <= 1'b1;
					div_ctl_q.bits  <= DIV_CNT_W'(INDEX_WIDTH);
					div_dvd_q       <= NW'(frame_q) << (NW - INDEX_WIDTH);
					div_dvs_q       <= DW'(cols_eff);
					state_q         <= ST_DIVA;
				end

				ST_DIVA: begin
					div_ctl_q.start <= 1'b0;
					if (div_done) begin
						mx_q      <= MW'(div_rem[7:0]);
						my_q      <= MW'(div_quo[INDEX_WIDTH-1:0]);
						wsh_q     <= POS_W'(cell_width_q);
						hsh_q     <= POS_W'(cell_height_q);
						sx_q      <= POS_W'(origin_x_q);
						sy_q      <= POS_W'(origin_y_q);
						mul_cnt_q <= MCW'(MW);
						state_q   <= ST_MUL;
					end
				end

				ST_MUL: begin
					// one multiplier bit per cycle; sums wrap at POS_W bits
					div_ctl_q.start <= 1'b0;
					if (mx_q[0]) begin
						sx_q <= sx_q + wsh_q;
					end
					if (my_q[0]) begin
						sy_q <= sy_q + hsh_q;
					end
					wsh_q     <= wsh_q << 1;
					hsh_q     <= hsh_q << 1;
					mx_q      <= mx_q >> 1;
					my_q      <= my_q >> 1;
					mul_cnt_q <= mul_cnt_q - 1'b1;
					if (mul_cnt_q == MCW'(1)) begin
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					// hold until the output register is free
					div_ctl_q.start <= 1'b0;
					if (out_free) begin
						o_chg_q      <= chg_q;
						o_frame_q    <= frame_q;
						o_playing_q  <= playing_q;
						o_finished_q <= finished_q;
						o_sx_q       <= sx_q;
						o_sy_q       <= sy_q;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					div_ctl_q.start <= 1'b0;
					state_q         <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_changed = o_chg_q;
	assign frame_index   = o_frame_q;
	assign is_playing    = o_playing_q;
	assign is_finished   = o_finished_q;
	assign source_x      = o_sx_q;
	assign source_y      = o_sy_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && chg_q) |-> elapsed_q < EW'(frame_period_q))
		else $error("elapsed time not below frame period after a step");

	a_finished_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_finished) |-> !is_playing)
		else $error("finished animation still reported as playing");

endmodule
